// File: rtl/sscg_pkg.sv
package sscg_pkg;

	// Message store geometry
	localparam int TEXT_LEN = 20;
	localparam int PosW     = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
	localparam int FillW    = $clog2(TEXT_LEN + 1);

	// Register reset values and indexes
	localparam logic [15:0] GRANT_RST = 16'd2000;
	localparam logic [7:0]  DEB_RST   = 8'd70;
	localparam logic        REG_GRANT = 1'b0;
	localparam logic        REG_DEB   = 1'b1;

	// Slot codes
	localparam logic [1:0] SLOT_NONE  = 2'd0;
	localparam logic [1:0] SLOT_ONE   = 2'd1;
	localparam logic [1:0] SLOT_THREE = 2'd2;

	// Characters
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Slot and timer state
	typedef struct packed {
		logic [1:0]  latch;
		logic [15:0] gcount;
		logic [7:0]  hold1;
		logic [7:0]  hold3;
		logic [1:0]  relay;
	} slot_st_t;

	// One result item
	typedef struct packed {
		logic       relay_one;
		logic       relay_three;
		logic [1:0] latched_slot;
		logic       slot_changed;
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic       text_valid;
		logic [7:0] text_byte;
		logic       text_last;
	} res_t;

endpackage

// File: rtl/slot_select_grant_controller_unit.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | cmd, button_one, button_three, rx_byte, rx_error
// result   | out_valid / out_ready  | relay_*, latched_slot, slot_changed, reply_*, text_*
// config   | cfg_we                 | cfg_index, cfg_data (16 bit)
//
// An item sits in an input register, then is processed once the output register
// is free and no message walk runs; each item gives one result, but a capture
// terminator gives none of its own and walks the message memory instead: read,
// then load the output register once it is free, for 20 results in all.
// Reset (arst_n low) clears all control state; the message memory is not cleared,
// a fill count marks the entries written since the last capture start.
// A new item is taken while a result waits in the output register.
module slot_select_grant_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic        button_one,
	input  logic        button_three,
	input  logic [7:0]  rx_byte,
	input  logic        rx_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        relay_one,
	output logic        relay_three,
	output logic [1:0]  latched_slot,
	output logic        slot_changed,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic        text_valid,
	output logic [7:0]  text_byte,
	output logic        text_last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import sscg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WT   = 2'd2;
	localparam logic [PosW-1:0] LAST = PosW'(TEXT_LEN - 1);

	logic [1:0]      st_q;
	logic [15:0]     grant_q;
	logic [7:0]      deb_q;
	slot_st_t        slot_q, tick_nx, slot_nx;
	logic [1:0]      rep_slot_q, rep_slot_nx;
	logic            cap_q, cap_nx;
	logic [PosW-1:0] wpos_q, wpos_nx;
	logic [FillW-1:0] fill_q, fill_nx;
	logic [PosW-1:0] idx_q;
	logic            rd_ok_q;
	logic            in_full_q;
	logic            cmd_q, b1_q, b3_q, err_q;
	logic [7:0]      byte_q;
	logic            out_valid_q;
	res_t            out_q, stat_res, emit_res;
	logic [7:0]      mem_rdata;
	logic            out_free, proc, term, wr_txt;
	logic            ld_stat, ld_emit;
	logic            rep_v;
	logic [7:0]      rep_b;
	logic            last_emit;

	function automatic logic last_pos(input logic [PosW-1:0] p);
		return p == LAST;
	endfunction

	function automatic logic [7:0] slot_char(input logic [1:0] s);
		logic [7:0] c;
		c = CH_DASH;
		if (s == SLOT_ONE) c = CH_ONE;
		else if (s == SLOT_THREE) c = CH_THREE;
		return c;
	endfunction

	// Tick update of slot state
	sscg_tick u_tick (
		.cur          (slot_q),
		.button_one   (b1_q),
		.button_three (b3_q),
		.debounce     (deb_q),
		.nxt          (tick_nx)
	);

	// Message store
	sscg_text_mem u_mem (
		.clk   (clk),
		.we    (proc && wr_txt),
		.waddr (wpos_q),
		.wdata (byte_q),
		.re    (st_q == ST_RD),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	assign in_ready = !in_full_q;
	assign out_free = !out_valid_q || out_ready;
	assign proc     = (st_q == ST_IDLE) && in_full_q && out_free;
	assign term     = cmd_q && !err_q && cap_q &&
			(byte_q == CH_CR || byte_q == CH_LF || byte_q == CH_NUL);
	assign last_emit = (idx_q == LAST);
	assign ld_stat  = proc && !term;
	assign ld_emit  = (st_q == ST_WT) && out_free;

	// Next state for one processed item
	always_comb begin
		slot_nx     = slot_q;
		rep_slot_nx = rep_slot_q;
		cap_nx      = cap_q;
		wpos_nx     = wpos_q;
		fill_nx     = fill_q;
		wr_txt      = 1'b0;
		rep_v       = 1'b0;
		rep_b       = 8'h00;
		if (!cmd_q) begin
			slot_nx = tick_nx;
		end else if (!err_q) begin
			if (cap_q) begin
				if (!term) begin
					wr_txt  = 1'b1;
					fill_nx = FillW'(wpos_q) + FillW'(1);
					wpos_nx = last_pos(wpos_q) ? LAST : wpos_q + PosW'(1);
				end
			end else begin
				case (byte_q)
					CH_V: begin
						rep_v       = 1'b1;
						rep_b       = slot_char(slot_q.latch);
						rep_slot_nx = slot_q.latch;
					end
					CH_O: begin
						rep_v = 1'b1;
						if (rep_slot_q == SLOT_ONE || rep_slot_q == SLOT_THREE) begin
							slot_nx.relay  = slot_q.relay |
									((rep_slot_q == SLOT_ONE) ? 2'b01 : 2'b10);
							slot_nx.gcount = grant_q;
							rep_b          = CH_D;
						end else begin
							rep_b = CH_N;
						end
					end
					CH_D: begin
						cap_nx  = 1'b1;
						wpos_nx = '0;
						fill_nx = '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Status result of a processed item
	always_comb begin
		stat_res              = '0;
		stat_res.relay_one    = slot_nx.relay[0];
		stat_res.relay_three  = slot_nx.relay[1];
		stat_res.latched_slot = slot_nx.latch;
		stat_res.slot_changed = slot_nx.latch != slot_q.latch;
		stat_res.reply_valid  = rep_v;
		stat_res.reply_byte   = rep_b;
	end

	// Message byte result; entries past the fill count read as space
	always_comb begin
		emit_res              = '0;
		emit_res.relay_one    = slot_q.relay[0];
		emit_res.relay_three  = slot_q.relay[1];
		emit_res.latched_slot = slot_q.latch;
		emit_res.reply_valid  = last_emit;
		emit_res.reply_byte   = last_emit ? CH_D : 8'h00;
		emit_res.text_valid   = 1'b1;
		emit_res.text_byte    = rd_ok_q ? mem_rdata : CH_SPACE;
		emit_res.text_last    = last_emit;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_q <= GRANT_RST;
			deb_q   <= DEB_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRANT) begin
				grant_q <= cfg_data;
			end else begin
				deb_q <= cfg_data[7:0];
			end
		end
	end

	// Hold the input transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			b1_q   <= button_one;
			b3_q   <= button_three;
			byte_q <= rx_byte;
			err_q  <= rx_error;
		end
	end

	// Control: process, walk the message, drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			slot_q      <= '0;
			rep_slot_q  <= SLOT_NONE;
			cap_q       <= 1'b0;
			wpos_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			rd_ok_q     <= 1'b0;
			in_full_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ld_stat || ld_emit || (out_valid_q && !out_ready);
			if (in_valid && in_ready) begin
				in_full_q <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (proc) begin
						in_full_q <= 1'b0;
						if (term) begin
							cap_q <= 1'b0;
							idx_q <= '0;
							st_q  <= ST_RD;
						end else begin
							slot_q      <= slot_nx;
							rep_slot_q  <= rep_slot_nx;
							cap_q       <= cap_nx;
							wpos_q      <= wpos_nx;
							fill_q      <= fill_nx;
						end
					end
				end
				ST_RD: begin
					rd_ok_q <= FillW'(idx_q) < fill_q;
					st_q    <= ST_WT;
				end
				ST_WT: begin
					if (out_free) begin
						if (last_emit) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + PosW'(1);
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ld_stat) begin
			out_q <= stat_res;
		end else if (ld_emit) begin
			out_q <= emit_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign relay_one    = out_q.relay_one;
	assign relay_three  = out_q.relay_three;
	assign latched_slot = out_q.latched_slot;
	assign slot_changed = out_q.slot_changed;
	assign reply_valid  = out_q.reply_valid;
	assign reply_byte   = out_q.reply_byte;
	assign text_valid   = out_q.text_valid;
	assign text_byte    = out_q.text_byte;
	assign text_last    = out_q.text_last;

	// Capture is off while the message is walked
	a_no_cap_emit: assert property (@(posedge clk) disable iff (!arst_n)
			(st_q != ST_IDLE) |-> !cap_q)
		else $error("capture active during message walk");

	// Write position and fill count stay inside the store
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
			(wpos_q <= LAST) && (fill_q <= FillW'(TEXT_LEN)))
		else $error("message position out of range");

	// Latched and reported slot codes never take the unused value
	a_slot_code: assert property (@(posedge clk) disable iff (!arst_n)
			(slot_q.latch != 2'd3) && (rep_slot_q != 2'd3))
		else $error("illegal slot code");

	// A walk ends in a last byte that also carries the reply
	a_last_reply: assert property (@(posedge clk) disable iff (!arst_n)
			(st_q == ST_WT && out_free && last_emit) |=>
			(out_valid_q && out_q.text_last && out_q.reply_valid && st_q == ST_IDLE))
		else $error("message walk ended without final reply");

endmodule

// File: rtl/sscg_text_mem.sv
module sscg_text_mem (
	input  logic                     clk,
	input  logic                     we,
	input  logic [sscg_pkg::PosW-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [sscg_pkg::PosW-1:0] raddr,
	output logic [7:0]               rdata
);
	import sscg_pkg::*;

	logic [7:0] mem [TEXT_LEN];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/sscg_tick.sv
module sscg_tick (
	input  sscg_pkg::slot_st_t cur,
	input  logic               button_one,
	input  logic               button_three,
	input  logic [7:0]         debounce,
	output sscg_pkg::slot_st_t nxt
);
	import sscg_pkg::*;

	slot_st_t s;

	always_comb begin
		s = cur;
		// Count down the grant timer
		if (cur.gcount != 16'd0) begin
			s.gcount = cur.gcount - 16'd1;
		end
		// Slot one hold counter, checked first
		if (button_one) begin
			if (s.latch == SLOT_NONE) begin
				s.hold1 = cur.hold1 + 8'd1;
				if (cur.hold1 == debounce) begin
					s.latch = SLOT_ONE;
				end
			end
		end else begin
			s.hold1 = 8'd0;
		end
		// Slot three hold counter sees the latch after slot one
		if (button_three) begin
			if (s.latch == SLOT_NONE) begin
				s.hold3 = cur.hold3 + 8'd1;
				if (cur.hold3 == debounce) begin
					s.latch = SLOT_THREE;
				end
			end
		end else begin
			s.hold3 = 8'd0;
		end
		// Drop latch and relays once idle and released
		if (s.gcount == 16'd0 && s.hold1 == 8'd0 && s.hold3 == 8'd0 &&
				s.latch != SLOT_NONE) begin
			s.relay = 2'b00;
			s.latch = SLOT_NONE;
		end
		nxt = s;
	end

endmodule
